/* hw/rtl/ccsf_pkg.sv */
package ccsf_pkg;

	localparam int FREQ_W      = 12;
	localparam int BIN_W       = 8;
	localparam int CAND_W      = 9;
	localparam int BIN_IDX_W   = 6;
	localparam int BAND_LOW_HZ = 200;
	localparam int RECIP_50    = 1311;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = 23;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [FREQ_W-1:0] PREF_RESET = 12'd1500;
	localparam logic [ADDR_W-1:0] ADDR_PREF  = 3'd0;

	typedef struct packed {
		logic [FREQ_W-1:0] station_freq_hz;
		logic              station_valid;
		logic              last_item;
	} station_req_t;

	typedef struct packed {
		logic [FREQ_W-1:0] clear_freq_hz;
		logic              all_occupied;
	} slot_res_t;

	typedef struct packed {
		logic mark;
		logic start;
		logic step;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic found;
		logic exhausted;
	} dp_sts_t;

	// (f - 200) / 50, truncated toward zero
	function automatic logic signed [BIN_W-1:0] bin_of(input logic [FREQ_W-1:0] f);
		logic signed [FREQ_W:0] diff;
		logic [FREQ_W-1:0]      mag;
		logic [PROD_W-1:0]      prod;
		logic [BIN_W-2:0]       q;
		diff = $signed({1'b0, f}) - $signed((FREQ_W+1)'(BAND_LOW_HZ));
		mag  = diff[FREQ_W] ? FREQ_W'(-diff) : diff[FREQ_W-1:0];
		prod = PROD_W'(mag) * PROD_W'(RECIP_50);
		q    = prod[PROD_W-1:RECIP_SHIFT];
		bin_of = diff[FREQ_W] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	// 200 + 50 * bin
	function automatic logic [FREQ_W-1:0] freq_of(input logic [BIN_IDX_W-1:0] b);
		freq_of = FREQ_W'(BAND_LOW_HZ) + {1'b0, b, 5'b0} + {2'b0, b, 4'b0}
			+ {5'b0, b, 1'b0};
	endfunction

endpackage

/* hw/rtl/clear_channel_slot_finder.sv */
// Channel   Handshake                      Payload
// in        in_valid / in_stall            in_req  (station_req_t)
// out       out_valid / out_stall          out_res (slot_res_t)
// config    psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// A non-last request does not stall; a valid station's mark lands in the mask at acceptance.
// A last request adds a search over distances 0 to NUM_BINS/2, one distance per cycle.
// in_stall is high during the search; a result waits in the output register under out_stall.
// Reset clears the mask, the output valid and sets preferred_freq_hz to 1500.
module clear_channel_slot_finder #(
	parameter int NUM_BINS = 52
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ccsf_pkg::station_req_t        in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ccsf_pkg::slot_res_t           out_res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccsf_pkg::ADDR_W-1:0]   paddr,
	input  logic [ccsf_pkg::DATA_W-1:0]   pwdata,
	output logic [ccsf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ccsf_pkg::*;

	logic [FREQ_W-1:0] pref_q;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PREF) ? DATA_W'(pref_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q <= PREF_RESET;
		end else if (psel & penable & pwrite & pready & (paddr == ADDR_PREF)) begin
			pref_q <= pwdata[FREQ_W-1:0];
		end
	end

	ccsf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.station_valid (in_req.station_valid),
		.last_item     (in_req.last_item),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.sts           (sts)
	);

	ccsf_datapath #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.station_freq (in_req.station_freq_hz),
		.pref_freq    (pref_q),
		.res          (out_res)
	);

endmodule

/* hw/rtl/ccsf_datapath.sv */
module ccsf_datapath #(
	parameter int NUM_BINS = 52
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ccsf_pkg::dp_cmd_t              cmd,
	output ccsf_pkg::dp_sts_t              sts,
	input  logic [ccsf_pkg::FREQ_W-1:0]    station_freq,
	input  logic [ccsf_pkg::FREQ_W-1:0]    pref_freq,
	output ccsf_pkg::slot_res_t            res
);
	import ccsf_pkg::*;

	localparam int R_MAX = NUM_BINS / 2;
	localparam int R_W   = $clog2(R_MAX + 1);

	logic [NUM_BINS-1:0]       mask_q;
	logic [NUM_BINS-1:0]       mask_set;
	logic [NUM_BINS-1:0]       lo_vec;
	logic [NUM_BINS-1:0]       hi_vec;
	logic [R_W-1:0]            r_q;
	slot_res_t                 res_q;
	logic signed [CAND_W-1:0]  st_c;
	logic signed [CAND_W-1:0]  pf_c;
	logic signed [CAND_W-1:0]  r_ext;
	logic signed [CAND_W-1:0]  cand_lo;
	logic signed [CAND_W-1:0]  cand_hi;
	logic                      found_lo;
	logic                      found_hi;

	assign st_c    = CAND_W'(bin_of(station_freq));
	assign pf_c    = CAND_W'(bin_of(pref_freq));
	assign r_ext   = $signed({{(CAND_W-R_W){1'b0}}, r_q});
	assign cand_lo = pf_c - r_ext;
	assign cand_hi = pf_c + r_ext;

	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			mask_set[i] = (st_c - $signed(CAND_W'(1)) == $signed(CAND_W'(i)))
				| (st_c == $signed(CAND_W'(i)))
				| (st_c + $signed(CAND_W'(1)) == $signed(CAND_W'(i)));
			lo_vec[i] = (cand_lo == $signed(CAND_W'(i))) & ~mask_q[i];
			hi_vec[i] = (cand_hi == $signed(CAND_W'(i))) & ~mask_q[i];
		end
	end

	assign found_lo      = |lo_vec;
	assign found_hi      = (r_q != '0) & (|hi_vec);
	assign sts.found     = found_lo | found_hi;
	assign sts.exhausted = (r_q == R_W'(R_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			r_q    <= '0;
		end else begin
			if (cmd.mark) begin
				mask_q <= mask_q | mask_set;
			end else if (cmd.load) begin
				mask_q <= '0;
			end
			if (cmd.start) begin
				r_q <= '0;
			end else if (cmd.step) begin
				r_q <= r_q + R_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (found_lo) begin
				res_q.clear_freq_hz <= freq_of(cand_lo[BIN_IDX_W-1:0]);
				res_q.all_occupied  <= 1'b0;
			end else if (found_hi) begin
				res_q.clear_freq_hz <= freq_of(cand_hi[BIN_IDX_W-1:0]);
				res_q.all_occupied  <= 1'b0;
			end else begin
				res_q.clear_freq_hz <= pref_freq;
				res_q.all_occupied  <= 1'b1;
			end
		end
	end

	assign res = res_q;

	a_mask_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> mask_q == '0)
		else $error("mask not cleared after result");
	a_r_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> r_q != R_W'(R_MAX))
		else $error("search stepped past its reach");

endmodule

/* hw/rtl/ccsf_ctrl.sv */
module ccsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              station_valid,
	input  logic              last_item,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ccsf_pkg::dp_cmd_t cmd,
	input  ccsf_pkg::dp_sts_t sts
);
	import ccsf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   acc_in;
	logic   done;
	logic   free;

	assign in_stall  = (state_q != ST_IDLE);
	assign acc_in    = in_valid & ~in_stall;
	assign done      = sts.found | sts.exhausted;
	assign free      = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	assign cmd.mark  = acc_in & station_valid;
	assign cmd.start = (state_q == ST_IDLE);
	assign cmd.step  = (state_q == ST_SEARCH) & ~done;
	assign cmd.load  = (state_q == ST_SEARCH) & done & free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in & last_item) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (cmd.load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rise_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SEARCH))
		else $error("result raised outside a search");
	a_no_mark_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mark && cmd.load))
		else $error("mark and result load in the same cycle");

endmodule
